// ===== rtl/care_pkg.sv =====
// Package for the collision-aware rank estimator: widths, constants, opcodes and state codes.
`default_nettype none

package care_pkg;

	localparam int WINDOW_DEPTH_DEF = 8;
	localparam int MAX_PARENTS_DEF  = 16;

	localparam int BE_W     = 3;
	localparam int CW_W     = 5;
	localparam int PROB_W   = 17;
	localparam int RANK_W   = 16;
	localparam int PCNT_W   = 5;
	localparam int MHRI_W   = 11;
	localparam int PW_W     = 33;   // Q1.32 power, up to 1.0
	localparam int MUL_A_W  = 33;
	localparam int MUL_B_W  = 11;
	localparam int MUL_W    = MUL_A_W + MUL_B_W;
	localparam int DIV_W    = 40;   // dividend and quotient shift register
	localparam int DIV_BITS = 8;    // quotient bits per cycle
	localparam int DIV_STEPS = DIV_W / DIV_BITS;
	localparam int DCNT_W   = $clog2(DIV_STEPS);

	localparam logic [BE_W-1:0]   BE_RESET   = 3'd3;
	localparam logic [BE_W-1:0]   BE_MAX     = 3'd5;
	localparam int                NBR_MIN    = 2;
	localparam logic [PROB_W-1:0] ONE_Q16    = 17'h10000;
	localparam logic [PW_W-1:0]   PW_ONE     = 33'h1_0000_0000;
	localparam logic [PW_W-1:0]   PW_HALF_LSB = 33'h0_0000_8000;
	localparam logic [RANK_W-1:0] RANK_INF   = 16'hFFFF;
	localparam logic [MHRI_W-1:0] MHRI_RESET = 11'd256;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 56;

	typedef enum logic [1:0] {
		OP_COLLISION = 2'd0,
		OP_SUCCESS   = 2'd1,
		OP_RANK_REQ  = 2'd2,
		OP_LRN_RESET = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_PROB = 5'b01000,
		ST_RANK = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/collision_aware_rank_estimator.sv =====
// Collision-aware rank estimator: event sequencer with a shared multiplier and divider.
//
// Input items arrive on s_tvalid/s_tready; s_tuser carries the opcode, s_tdata the
// DAG flag, parent count, parent flag, parent rank and base rank. A transfer with a
// collision, success or learning-reset opcode updates state on transfer and yields
// no result. A rank request runs a sequencer over one shared 33x11 multiplier and a
// radix-256 long divider (8 quotient bits per cycle): each of the k-1 power factors
// takes one multiply step and one division, then the probability, the window average
// (a division by WINDOW_DEPTH) and the rank follow; k is the neighbor count
// (2..MAX_PARENTS). s_tready stays low while a rank request runs.
// The result is held in an output register until m_tready takes it; the next input
// can be accepted while it waits, but a new result waits in the final state until
// the output register is free. The probability window is a small memory with one
// valid bit per entry and a running sum, so no clearing pass is needed.
// Reset (arst_n low) restores the exponent 3, neighbor count 2, an empty window,
// zero mean and a rank increase of 256. cfg_we writes min_hop_rank_increase.
`default_nettype none

module collision_aware_rank_estimator
	import care_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int MAX_PARENTS  = MAX_PARENTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	// dag_present[0], parent_count[5:1], has_parent[6], parent_rank[22:7],
	// node_rank[38:23], zero pad[39]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  wire logic [1:0]            s_tuser,
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	// rank[15:0], collision_prob[32:16], mean_prob[49:33], reward_positive[50],
	// zero pad[55:51]
	output      logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [MHRI_W-1:0]     cfg_wdata
);

	localparam int K_W   = $clog2(MAX_PARENTS + 1);
	localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W = PROB_W + $clog2(WINDOW_DEPTH);
	localparam int DVS_W = ($clog2(WINDOW_DEPTH + 1) > CW_W) ? $clog2(WINDOW_DEPTH + 1) : CW_W;

	state_t st_q;

	logic [MHRI_W-1:0] mhri_q;
	logic [BE_W-1:0]   be_q;
	logic [K_W-1:0]    k_q;
	logic [K_W-1:0]    fcnt_q;
	logic [POS_W-1:0]  pos_q;
	logic [PROB_W-1:0] mean_q;
	logic [PROB_W-1:0] p_q;
	logic [PROB_W-1:0] avg_q;
	logic [SUM_W-1:0]  sum_q;
	logic [PW_W-1:0]   pw_q;
	logic              has_parent_q;
	logic [RANK_W-1:0] parent_rank_q;
	logic [RANK_W-1:0] node_rank_q;

	logic [DIV_W-1:0]  dd_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              div_avg_q;

	logic [PROB_W-1:0] win_mem [WINDOW_DEPTH];
	logic [PROB_W-1:0] win_rd_q;
	logic [WINDOW_DEPTH-1:0] win_vld_q;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// input unpack
	op_t               in_op;
	logic              in_dag;
	logic [PCNT_W-1:0] in_pcnt;
	logic              in_has_parent;
	logic [RANK_W-1:0] in_parent_rank;
	logic [RANK_W-1:0] in_node_rank;
	logic              in_xfer;

	assign in_op          = op_t'(s_tuser);
	assign in_dag         = s_tdata[0];
	assign in_pcnt        = s_tdata[5:1];
	assign in_has_parent  = s_tdata[6];
	assign in_parent_rank = s_tdata[22:7];
	assign in_node_rank   = s_tdata[38:23];

	assign s_tready = (st_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// new neighbor count from the parent count: clamp to MAX_PARENTS, floor at 2
	logic [K_W-1:0] k_new;
	always_comb begin
		if (32'(in_pcnt) > 32'(MAX_PARENTS)) begin
			k_new = K_W'(MAX_PARENTS);
		end else if (in_pcnt > PCNT_W'(1)) begin
			k_new = K_W'(in_pcnt);
		end else begin
			k_new = K_W'(NBR_MIN);
		end
	end

	logic [K_W-1:0] k_eff;
	assign k_eff = in_dag ? k_new : k_q;

	// contention window 2^BE-1 clamped to 1..31
	logic [CW_W-1:0] cw;
	assign cw = (be_q == '0) ? CW_W'(1) : CW_W'((6'd1 << be_q) - 6'd1);

	// shared multiplier
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_W-1:0]   mul_p;
	always_comb begin
		if (st_q == ST_MUL) begin
			mul_a = pw_q;
			mul_b = MUL_B_W'(cw - CW_W'(1));
		end else begin
			mul_a = MUL_A_W'(p_q);
			mul_b = mhri_q;
		end
	end
	assign mul_p = mul_a * mul_b;

	// shared divider: eight restoring steps per cycle
	logic [DIV_W-1:0] dd_nxt;
	logic [DVS_W:0]   rr;
	always_comb begin
		dd_nxt = dd_q;
		rr     = {1'b0, rem_q};
		for (int j = 0; j < DIV_BITS; j++) begin
			rr     = {rr[DVS_W-1:0], dd_nxt[DIV_W-1]};
			dd_nxt = {dd_nxt[DIV_W-2:0], 1'b0};
			if (rr >= {1'b0, dvs_q}) begin
				rr        = rr - {1'b0, dvs_q};
				dd_nxt[0] = 1'b1;
			end
		end
	end

	// probability from the Q1.32 power, rounded half up to Q1.16
	logic [PW_W-1:0]   pw_rnd;
	logic [PROB_W-1:0] p_new;
	assign pw_rnd = pw_q + PW_HALF_LSB;
	assign p_new  = ONE_Q16 - pw_rnd[PW_W-1:16];

	// window running sum: drop the entry being replaced, add the new sample
	logic [PROB_W-1:0] win_old;
	logic [SUM_W-1:0]  sum_new;
	assign win_old = win_vld_q[pos_q] ? win_rd_q : '0;
	assign sum_new = sum_q - SUM_W'(win_old) + SUM_W'(p_new);

	logic [POS_W-1:0] pos_nxt;
	assign pos_nxt = (pos_q == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_q + POS_W'(1);

	// rank and mean
	logic [PROB_W:0]   mean_sum;
	logic [PROB_W-1:0] mean_new;
	logic [RANK_W:0]   rank_sum;
	logic [RANK_W-1:0] rank_new;
	assign mean_sum = {1'b0, mean_q} + {1'b0, avg_q};
	assign mean_new = mean_sum[PROB_W:1];
	assign rank_sum = {1'b0, parent_rank_q} + (RANK_W+1)'(mul_p[27:16]);

	always_comb begin
		priority if (node_rank_q == '0) begin
			rank_new = RANK_INF;
		end else if (!has_parent_q) begin
			rank_new = node_rank_q;
		end else if (rank_sum[RANK_W]) begin
			rank_new = RANK_INF;
		end else begin
			rank_new = rank_sum[RANK_W-1:0];
		end
	end

	logic rank_go;
	assign rank_go = (st_q == ST_RANK) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mhri_q <= MHRI_RESET;
		end else if (cfg_we) begin
			mhri_q <= cfg_wdata;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			be_q      <= BE_RESET;
			k_q       <= K_W'(NBR_MIN);
			pos_q     <= '0;
			mean_q    <= '0;
			sum_q     <= '0;
			win_vld_q <= '0;
			fcnt_q    <= '0;
			dcnt_q    <= '0;
			div_avg_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_xfer) begin
						unique case (in_op)
							OP_COLLISION: begin
								if (be_q < BE_MAX) be_q <= be_q + BE_W'(1);
							end
							OP_SUCCESS: begin
								if (be_q != '0) be_q <= be_q - BE_W'(1);
							end
							OP_LRN_RESET: begin
								be_q   <= BE_RESET;
								k_q    <= K_W'(NBR_MIN);
								pos_q  <= '0;
								mean_q <= '0;
							end
							OP_RANK_REQ: begin
								k_q    <= k_eff;
								fcnt_q <= k_eff - K_W'(1);
								st_q   <= ST_MUL;
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					dcnt_q    <= '0;
					div_avg_q <= 1'b0;
					st_q      <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
						if (div_avg_q) begin
							st_q <= ST_RANK;
						end else begin
							fcnt_q <= fcnt_q - K_W'(1);
							st_q   <= (fcnt_q == K_W'(1)) ? ST_PROB : ST_MUL;
						end
					end
				end
				ST_PROB: begin
					win_vld_q[pos_q] <= 1'b1;
					sum_q     <= sum_new;
					pos_q     <= pos_nxt;
					dcnt_q    <= '0;
					div_avg_q <= 1'b1;
					st_q      <= ST_DIV;
				end
				ST_RANK: begin
					if (rank_go) begin
						mean_q <= mean_new;
						st_q   <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			has_parent_q  <= in_has_parent;
			parent_rank_q <= in_parent_rank;
			node_rank_q   <= in_node_rank;
			pw_q          <= PW_ONE;
		end
		if (st_q == ST_MUL) begin
			dd_q  <= DIV_W'(mul_p);
			rem_q <= '0;
			dvs_q <= DVS_W'(cw);
		end else if (st_q == ST_DIV) begin
			dd_q  <= dd_nxt;
			rem_q <= rr[DVS_W-1:0];
			if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
				if (div_avg_q) begin
					avg_q <= dd_nxt[PROB_W-1:0];
				end else begin
					pw_q <= dd_nxt[PW_W-1:0];
				end
			end
		end else if (st_q == ST_PROB) begin
			p_q   <= p_new;
			dd_q  <= DIV_W'(sum_new);
			rem_q <= '0;
			dvs_q <= DVS_W'(WINDOW_DEPTH);
		end
	end

	// window memory: registered read at the current position
	always_ff @(posedge clk) begin
		if (st_q == ST_PROB) begin
			win_mem[pos_q] <= p_new;
		end
		win_rd_q <= win_mem[pos_q];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (rank_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rank_go) begin
			m_tdata_q <= {5'd0, (p_q < mean_new), mean_new, p_q, rank_new};
		end
	end

	a_be_range: assert property (@(posedge clk) disable iff (!arst_n) be_q <= BE_MAX)
		else $error("backoff exponent out of range");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q >= K_W'(NBR_MIN)) && (32'(k_q) <= 32'(MAX_PARENTS)))
		else $error("neighbor count out of range");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < 32'(WINDOW_DEPTH))
		else $error("window position out of range");

	a_factor_left: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MUL) |-> (fcnt_q != '0))
		else $error("power step started with no factor left");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the collision-aware rank estimator stream block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import care_pkg::*;

	localparam int WIN_DEPTH   = WINDOW_DEPTH_DEF;
	localparam int PARENT_CAP  = MAX_PARENTS_DEF;
	localparam int CW_CEIL     = 31;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE      = 20;

	typedef struct {
		op_t       opcode;
		bit        dag_present;
		bit [4:0]  parent_count;
		bit        has_parent;
		bit [15:0] parent_rank;
		bit [15:0] node_rank;
	} net_event_t;

	typedef struct {
		logic [RANK_W-1:0] rank;
		logic [PROB_W-1:0] prob;
		logic [PROB_W-1:0] mean;
		logic              reward;
	} rank_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = OP_COLLISION;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [MHRI_W-1:0]     cfg_wdata = '0;

	net_event_t   event_q[$];
	rank_result_t rank_result_q[$];

	// estimator state as the block should hold it
	logic [BE_W-1:0]   bexp;
	int unsigned       nbr_cnt;
	logic [PROB_W-1:0] prob_win [WIN_DEPTH];
	int unsigned       win_pos;
	logic [PROB_W-1:0] prob_mean;
	logic [PROB_W-1:0] prob_now;
	logic [MHRI_W-1:0] rank_inc;

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  fail_cnt = 0;
	int  quiet_cycles = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	bit  hold_ack = 1'b0;
	bit  tx_offer;
	rank_result_t want;

	collision_aware_rank_estimator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [PROB_W-1:0] collision_prob_q16(logic [BE_W-1:0] be,
			int unsigned k);
		longint unsigned pw;
		longint unsigned cw;
		int unsigned     i;
		cw = (64'd1 << be) - 1;
		if (cw < 1) cw = 1;
		if (cw > CW_CEIL) cw = CW_CEIL;
		if (k < 1) k = 1;
		pw = 64'd1 << 32;
		for (i = 1; i < k; i++)
			pw = (pw * (cw - 1)) / cw;
		return ONE_Q16 - PROB_W'((pw + 64'd32768) >> 16);
	endfunction

	task automatic reset_learning();
		bexp = BE_RESET;
		nbr_cnt = NBR_MIN;
		win_pos = 0;
		prob_mean = '0;
	endtask

	// Apply one accepted event to the estimator state; queue the result of a rank request.
	task automatic advance_estimator(net_event_t e);
		longint unsigned sum;
		longint unsigned inc;
		int unsigned     n;
		int unsigned     r;
		rank_result_t    res;
		case (e.opcode)
			OP_COLLISION: if (bexp < BE_MAX) bexp++;
			OP_SUCCESS:   if (bexp > 0) bexp--;
			OP_LRN_RESET: reset_learning();
			default: begin
				if (e.dag_present) begin
					n = e.parent_count;
					if (n > PARENT_CAP) n = PARENT_CAP;
					nbr_cnt = (n > 1) ? n : NBR_MIN;
				end
				prob_now = collision_prob_q16(bexp, nbr_cnt);
				if (win_pos >= WIN_DEPTH) win_pos = 0;
				prob_win[win_pos] = prob_now;
				win_pos++;
				if (win_pos >= WIN_DEPTH) win_pos = 0;
				sum = 0;
				for (int i = 0; i < WIN_DEPTH; i++) sum += prob_win[i];
				prob_mean = PROB_W'((prob_mean + PROB_W'(sum / WIN_DEPTH)) >> 1);
				if (e.node_rank == 0) begin
					r = RANK_INF;
				end else if (!e.has_parent) begin
					r = e.node_rank;
				end else begin
					inc = (longint'(prob_now) * rank_inc) >> 16;
					r = e.parent_rank + int'(inc);
					if (r > RANK_INF) r = RANK_INF;
				end
				res.rank = RANK_W'(r);
				res.prob = prob_now;
				res.mean = prob_mean;
				res.reward = prob_now < prob_mean;
				rank_result_q.push_back(res);
			end
		endcase
	endtask

	// Sender: hold an offered item until it transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			tx_offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				advance_estimator(event_q.pop_front());
				tx_offer = 1'b0;
			end
			if (!tx_offer && event_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
				tx_offer = 1'b1;
			s_tvalid <= tx_offer;
			if (tx_offer) begin
				s_tdata <= {1'b0, event_q[0].node_rank, event_q[0].parent_rank,
					event_q[0].has_parent, event_q[0].parent_count, event_q[0].dag_present};
				s_tuser <= event_q[0].opcode;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(99) >= recv_stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (rank_result_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				fail_cnt++;
			end else begin
				want = rank_result_q.pop_front();
				if (m_tdata[15:0] !== want.rank) begin
					$display("%0t: rank expected %0d actual %0d", $time, want.rank,
						m_tdata[15:0]);
					fail_cnt++;
				end
				if (m_tdata[32:16] !== want.prob) begin
					$display("%0t: collision_prob expected %0d actual %0d", $time, want.prob,
						m_tdata[32:16]);
					fail_cnt++;
				end
				if (m_tdata[49:33] !== want.mean) begin
					$display("%0t: mean_prob expected %0d actual %0d", $time, want.mean,
						m_tdata[49:33]);
					fail_cnt++;
				end
				if (m_tdata[50] !== want.reward) begin
					$display("%0t: reward_positive expected %0d actual %0d", $time,
						want.reward, m_tdata[50]);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing transfers for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic add_event(op_t op, bit dag, bit [4:0] pcnt, bit hasp, bit [15:0] prank,
			bit [15:0] brank);
		net_event_t e;
		e.opcode = op;
		e.dag_present = dag;
		e.parent_count = pcnt;
		e.has_parent = hasp;
		e.parent_rank = prank;
		e.node_rank = brank;
		event_q.push_back(e);
	endtask

	task automatic add_random_event(int rank_pct);
		op_t op;
		int  pick;
		if ($urandom_range(99) < rank_pct) begin
			op = OP_RANK_REQ;
		end else begin
			pick = $urandom_range(9);
			op = (pick < 4) ? OP_COLLISION : (pick < 8) ? OP_SUCCESS : OP_LRN_RESET;
		end
		// keep neighbor counts mostly small so rank requests stay short
		add_event(op, 1'($urandom_range(1)),
			5'(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(5)),
			$urandom_range(3) != 0,
			16'(($urandom_range(7) == 0) ? 16'hFFFF - $urandom_range(255) : $urandom),
			16'(($urandom_range(9) == 0) ? 0 : $urandom));
	endtask

	// Wait until every item has transferred and every result has arrived.
	task automatic drain();
		while (event_q.size() > 0 || s_tvalid || rank_result_q.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_rank_increase(logic [MHRI_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		rank_inc = value;
		@(negedge clk);
	endtask

	task automatic run_phase(logic [MHRI_W-1:0] value, int sidle, int rstall, int count,
			int rank_pct);
		drain();
		write_rank_increase(value);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		repeat (count) add_random_event(rank_pct);
	endtask

	initial begin
		bexp = BE_RESET;
		nbr_cnt = NBR_MIN;
		win_pos = 0;
		prob_mean = '0;
		prob_now = '0;
		rank_inc = MHRI_RESET;
		for (int i = 0; i < WIN_DEPTH; i++) prob_win[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: rank forms, exponent bounds, parent count clamps, learning reset
		write_rank_increase(11'd1024);
		add_event(OP_RANK_REQ, 0, 5'd0, 1, 16'h0000, 16'h0001);
		add_event(OP_RANK_REQ, 0, 5'd0, 1, 16'h1234, 16'h0000);
		add_event(OP_RANK_REQ, 0, 5'd0, 0, 16'h0000, 16'hFFFF);
		add_event(OP_RANK_REQ, 0, 5'd0, 1, 16'hFFFF, 16'h0005);
		repeat (3) add_event(OP_COLLISION, 1, 5'd31, 1, 16'hFFFF, 16'hFFFF);
		add_event(OP_RANK_REQ, 1, 5'd16, 1, 16'd1000, 16'd7);
		add_event(OP_RANK_REQ, 1, 5'd31, 1, 16'd2000, 16'd7);
		add_event(OP_RANK_REQ, 1, 5'd0, 1, 16'd3000, 16'd7);
		add_event(OP_RANK_REQ, 1, 5'd1, 1, 16'd4000, 16'd7);
		repeat (6) add_event(OP_SUCCESS, 0, 5'd0, 0, 16'h0000, 16'h0000);
		add_event(OP_RANK_REQ, 1, 5'd5, 1, 16'hFFF0, 16'd9);
		add_event(OP_LRN_RESET, 1, 5'd31, 1, 16'hFFFF, 16'hFFFF);
		add_event(OP_RANK_REQ, 0, 5'd0, 1, 16'd100, 16'd9);
		add_event(OP_COLLISION, 0, 5'd0, 0, 16'h0000, 16'h0000);
		add_event(OP_RANK_REQ, 1, 5'd8, 1, 16'h7FFF, 16'hFFFF);

		run_phase(11'd1, 0, 0, 170, 40);
		run_phase(11'd2047, 59, 0, 170, 40);
		run_phase(11'd0, 0, 59, 170, 40);
		run_phase(11'($urandom_range(1024, 1)), 25, 25, 170, 40);

		// back-pressure: stop the receiver while the sender keeps offering items, mostly rank requests
		run_phase(11'd256, 0, 0, 0, 0);
		hold_req = ~hold_req;
		repeat (50) add_random_event(90);

		drain();
		repeat (40) @(posedge clk);
		if (rank_result_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, rank_result_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
